[rtl/edfts_pkg.sv]
// Shared constants, types and state encoding for the EDF tick scheduler.
package edfts_pkg;

  // Number of task entries, one cell each
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = IDX_W;
  localparam int TASK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int TIME_W    = 32;
  localparam int WORK_W    = 16;

  // Opcodes of the input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Best candidate so far, handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] deadline;
    logic [IDX_W-1:0]  idx;
    logic              last;     // picking it finishes the job
  } cand_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;     // write the load word into this cell
    logic commit;   // this cell won the tick
    logic part;     // cell index below task_count
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

[rtl/edfts_cell.sv]
// One task entry of the scheduler chain: task state plus one compare stage.
module edfts_cell (
  input  logic                        clk,
  input  edfts_pkg::cell_ctl_t        ctl,
  input  logic [edfts_pkg::IDX_W-1:0] cell_idx,
  input  logic [31:0]                 now,
  input  logic [15:0]                 ld_burst,
  input  logic [31:0]                 ld_deadline,
  input  logic [15:0]                 ld_period,
  input  edfts_pkg::cand_t            cand_in,
  output edfts_pkg::cand_t            cand_out
);
  import edfts_pkg::*;

  logic [WORK_W-1:0] burst_r,  burst_nxt;
  logic [WORK_W-1:0] period_r, period_nxt;
  logic [WORK_W-1:0] work_r,   work_nxt;
  logic [TIME_W-1:0] dl_r,     dl_nxt;
  logic [TIME_W-1:0] rel_r,    rel_nxt;
  cand_t             cand_r,   cand_nxt;

  logic              elig;
  logic              take;
  logic [TIME_W:0]   rel_sum;
  logic [TIME_W:0]   dl_sum;

  // Eligible: taking part, released, work left
  assign elig = ctl.part && (now >= rel_r) && (work_r != '0);
  // Strictly earlier deadline wins; ties stay with the lower index upstream
  assign take = elig && (!cand_in.found || (dl_r < cand_in.deadline));

  always_comb begin
    if (take) begin
      cand_nxt.found    = 1'b1;
      cand_nxt.deadline = dl_r;
      cand_nxt.idx      = cell_idx;
      cand_nxt.last     = (work_r == WORK_W'(1));
    end else begin
      cand_nxt = cand_in;
    end
  end

  // Next release and deadline; release + 2*period saturates alike
  assign rel_sum = {1'b0, rel_r} + {{(TIME_W-WORK_W+1){1'b0}}, period_r};
  assign dl_sum  = {1'b0, rel_r} + {{(TIME_W-WORK_W){1'b0}}, period_r, 1'b0};

  // Task state update: load word or commit of a won tick
  always_comb begin
    burst_nxt  = burst_r;
    period_nxt = period_r;
    work_nxt   = work_r;
    dl_nxt     = dl_r;
    rel_nxt    = rel_r;
    if (ctl.load) begin
      burst_nxt  = ld_burst;
      period_nxt = ld_period;
      work_nxt   = ld_burst;
      dl_nxt     = ld_deadline;
      rel_nxt    = '0;
    end else if (ctl.commit) begin
      if (work_r == WORK_W'(1)) begin
        work_nxt = burst_r;
        rel_nxt  = rel_sum[TIME_W] ? '1 : rel_sum[TIME_W-1:0];
        dl_nxt   = dl_sum[TIME_W]  ? '1 : dl_sum[TIME_W-1:0];
      end else begin
        work_nxt = work_r - WORK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    burst_r  <= burst_nxt;
    period_r <= period_nxt;
    work_r   <= work_nxt;
    dl_r     <= dl_nxt;
    rel_r    <= rel_nxt;
    cand_r   <= cand_nxt;
  end

  assign cand_out = cand_r;

endmodule

[rtl/edf_tick_scheduler_top.sv]
// Top level: sequencer, time counter and the chain of task cells.
// A load word takes effect at the accepting edge and leaves busy low.
// A tick word holds busy through a scan, in which the candidate ripples down
// the cell chain one stage a cycle, and a commit cycle; out_valid is registered
// from commit, and no new word is accepted until busy falls after the commit.
// Synchronous active-low reset clears time, task_count, out_valid and the sequencer.
module edf_tick_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [3:0]  in_task_index,
  input  logic [15:0] in_burst,
  input  logic [31:0] in_first_deadline,
  input  logic [15:0] in_period,
  output logic        out_valid,
  output logic [31:0] out_tick_time,
  output logic        out_busy_res,
  output logic [3:0]  out_task_run,
  output logic        out_job_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_task_count
);
  import edfts_pkg::*;

  state_t             st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [COUNT_W-1:0] task_count_r;
  logic               out_valid_r;
  logic [TIME_W-1:0]  out_time_r;
  logic               out_busy_r;
  logic [TASK_W-1:0]  out_task_r;
  logic               out_done_r;

  logic               accept;
  logic               tick_go;
  logic               load_go;
  logic               commit;
  logic               scan_end;
  cand_t              chain [MAX_TASKS+1];
  cell_ctl_t          ctl   [MAX_TASKS];
  cand_t              fin;

  assign accept   = start && !busy;
  assign tick_go  = accept && (in_op == OP_TICK);
  assign load_go  = accept && (in_op == OP_LOAD);
  assign scan_end = (cnt_r == CNT_W'(MAX_TASKS - 1));
  assign fin      = chain[MAX_TASKS];

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (tick_go)  st_nxt = ST_SCAN;
      ST_SCAN:   if (scan_end) st_nxt = ST_COMMIT;
      ST_COMMIT: st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy   = 1'b1;
    commit = 1'b0;
    unique case (st_r)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN:   busy = 1'b1;
      ST_COMMIT: commit = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assign cnt_nxt = (st_r == ST_SCAN) ? cnt_r + CNT_W'(1) : '0;
  assign now_nxt = (commit && (now_r != '1)) ? now_r + TIME_W'(1) : now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      cnt_r        <= '0;
      now_r        <= '0;
      task_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      now_r       <= now_nxt;
      out_valid_r <= commit;
      if (cfg_valid && cfg_ready) begin
        task_count_r <= cfg_task_count;
      end
    end
  end

  // Result word, captured at commit
  always_ff @(posedge clk) begin
    if (commit) begin
      out_time_r <= now_r;
      out_busy_r <= fin.found;
      out_task_r <= fin.found ? TASK_W'(fin.idx) : '0;
      out_done_r <= fin.found && fin.last;
    end
  end

  // Chain of task cells; the head sees no candidate
  assign chain[0] = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    assign ctl[k].load   = load_go && (32'(in_task_index) == k);
    assign ctl[k].commit = commit && fin.found && (fin.idx == IDX_W'(k));
    assign ctl[k].part   = (32'(task_count_r) > k);

    edfts_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[k]),
      .cell_idx    (IDX_W'(k)),
      .now         (now_r),
      .ld_burst    (in_burst),
      .ld_deadline (in_first_deadline),
      .ld_period   (in_period),
      .cand_in     (chain[k]),
      .cand_out    (chain[k+1])
    );
  end

  assign cfg_ready     = !busy;
  assign out_valid     = out_valid_r;
  assign out_tick_time = out_time_r;
  assign out_busy_res  = out_busy_r;
  assign out_task_run  = out_task_r;
  assign out_job_done  = out_done_r;

  // A result only follows a commit cycle
  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == ST_COMMIT))
    else $error("result strobe without commit");

  // Commit lasts one cycle
  a_commit_single: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COMMIT) |=> (st_r == ST_IDLE))
    else $error("commit not followed by idle");

  // An accepted tick starts the scan
  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> (st_r == ST_SCAN) && (cnt_r == '0))
    else $error("tick did not start scan");

  // Idle ticks report no task and no finished job
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_task_run == '0) && !out_job_done)
    else $error("idle result carries task data");

endmodule
